/* rtl/xxh_pkg.sv */
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, command/status types and helpers shared by the XXH64 block.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam int unsigned CNT_W  = 4;
    localparam int unsigned ADDR_W = 3;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    localparam logic [ADDR_W-1:0] REG_SEED = '0;

    localparam logic [CNT_W-1:0] CNT_FULL = 4'd8;
    localparam logic [CNT_W-1:0] CNT_HALF = 4'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ABS_INIT,
        ST_LR1,
        ST_LR2,
        ST_FOLD_START,
        ST_FA1,
        ST_FA2,
        ST_FA3,
        ST_ADDLEN,
        ST_TAIL_CHK,
        ST_TW1,
        ST_TW2,
        ST_TW3,
        ST_W4A,
        ST_W4B,
        ST_BYTE_CHK,
        ST_B1,
        ST_B2,
        ST_AV1,
        ST_AV2,
        ST_EMIT
    } xxh_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_STORE,
        OP_INIT,
        OP_LR1,
        OP_LR2,
        OP_FOLDSUM,
        OP_SHORT,
        OP_FA1,
        OP_TW1,
        OP_XORT,
        OP_FA3,
        OP_TW3,
        OP_ADDLEN,
        OP_W4A,
        OP_W4B,
        OP_B1,
        OP_B2,
        OP_AV1,
        OP_AV2,
        OP_EMIT
    } xxh_op_t;

    typedef struct packed {
        xxh_op_t    op;
        logic       apply;
        logic       mul_start;
        logic       accept;
        logic [1:0] idx;
        logic [2:0] pos;
    } xxh_cmd_t;

    typedef struct packed {
        logic             last;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       nbuf;
        logic             seen;
        logic             mul_done;
        logic             out_full;
    } xxh_status_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage

/* rtl/xxh_stream_if.sv */
// ----------------------------------------------------------------------------
// xxh_stream_if
// Valid/ready channels for message words in and digests out.
// ----------------------------------------------------------------------------
interface xxh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface xxh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash;

    modport source (output valid, hash, input ready);
    modport sink   (input valid, hash, output ready);
endinterface

/* rtl/xxh_mul.sv */
// ----------------------------------------------------------------------------
// xxh_mul
// 64x64 multiply, low 64 bits, on one shared 32x32 multiplier in 3 steps.
// ----------------------------------------------------------------------------
module xxh_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] prod
);
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] lo_reg;
    logic [31:0] cr_reg;
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic        done_reg;
    logic [31:0] mx_a;
    logic [31:0] mx_b;
    logic [63:0] pm;

    always_comb
    begin
        case (step_reg)
            2'd1:
            begin
                mx_a = a_reg[31:0];
                mx_b = b_reg[31:0];
            end
            2'd2:
            begin
                mx_a = a_reg[31:0];
                mx_b = b_reg[63:32];
            end
            default:
            begin
                mx_a = a_reg[63:32];
                mx_b = b_reg[31:0];
            end
        endcase
    end

    assign pm = mx_a * mx_b;

    always_comb
    begin
        case (step_reg)
            2'd0:    step_next = start ? 2'd1 : 2'd0;
            2'd1:    step_next = 2'd2;
            2'd2:    step_next = 2'd3;
            default: step_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (step_reg == 2'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        case (step_reg)
            2'd1:    lo_reg <= pm;
            2'd2:    cr_reg <= pm[31:0];
            2'd3:    cr_reg <= cr_reg + pm[31:0];
            default: ;
        endcase
    end

    assign done = done_reg;
    assign prod = lo_reg + {cr_reg, 32'h0};

endmodule

/* rtl/xxh_datapath.sv */
// ----------------------------------------------------------------------------
// xxh_datapath
// Lane accumulators, stripe buffer, hash register and the shared multiplier.
// ----------------------------------------------------------------------------
module xxh_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  xxh_pkg::xxh_cmd_t      cmd,
    output xxh_pkg::xxh_status_t   status,
    input  logic [63:0]            seed,
    input  logic [63:0]            in_word,
    input  logic [3:0]             in_count,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [63:0]            out_hash
);
    import xxh_pkg::*;

    logic [63:0]      acc_reg [4];
    logic [63:0]      sbuf_reg [3];
    logic [63:0]      word_reg;
    logic [63:0]      h_reg;
    logic [63:0]      t_reg;
    logic [63:0]      len_reg;
    logic [63:0]      hash_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       nbuf_reg;
    logic             last_reg;
    logic             seen_reg;
    logic             full_reg;

    logic [CNT_W-1:0] cnt_sat;
    logic [63:0]      word_masked;
    logic [63:0]      wsrc;
    logic [63:0]      mul_a;
    logic [63:0]      mul_b;
    logic [63:0]      prod;
    logic             mul_done;
    logic [7:0]       byte_sel;

    assign cnt_sat = (in_count > CNT_FULL) ? CNT_FULL : in_count;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word_masked[i*8 +: 8] = (!in_last || (CNT_W'(i) < cnt_sat)) ?
                                    in_word[i*8 +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        case (cmd.idx)
            2'd0:    wsrc = sbuf_reg[0];
            2'd1:    wsrc = sbuf_reg[1];
            2'd2:    wsrc = sbuf_reg[2];
            default: wsrc = word_reg;
        endcase
    end

    assign byte_sel = word_reg[{cmd.pos, 3'b000} +: 8];

    always_comb
    begin
        case (cmd.op)
            OP_LR1, OP_TW1:
            begin
                mul_a = wsrc;
                mul_b = PRIME2;
            end
            OP_FA1:
            begin
                mul_a = acc_reg[cmd.idx];
                mul_b = PRIME2;
            end
            OP_LR2, OP_XORT:
            begin
                mul_a = t_reg;
                mul_b = PRIME1;
            end
            OP_FA3:
            begin
                mul_a = h_reg;
                mul_b = PRIME1;
            end
            OP_TW3:
            begin
                mul_a = rotl64(h_reg, 27);
                mul_b = PRIME1;
            end
            OP_W4A:
            begin
                mul_a = {32'h0, word_reg[31:0]};
                mul_b = PRIME1;
            end
            OP_W4B:
            begin
                mul_a = rotl64(h_reg, 23);
                mul_b = PRIME2;
            end
            OP_B1:
            begin
                mul_a = {56'h0, byte_sel};
                mul_b = PRIME5;
            end
            OP_B2:
            begin
                mul_a = rotl64(h_reg, 11);
                mul_b = PRIME1;
            end
            OP_AV1:
            begin
                mul_a = h_reg ^ (h_reg >> 33);
                mul_b = PRIME2;
            end
            OP_AV2:
            begin
                mul_a = h_reg ^ (h_reg >> 29);
                mul_b = PRIME3;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    xxh_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    // control-like message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbuf_reg <= 2'd0;
            len_reg  <= '0;
            seen_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                full_reg <= 1'b0;
            if (cmd.accept)
                len_reg <= len_reg + (in_last ? 64'(cnt_sat) : 64'd8);
            if (cmd.apply)
            begin
                case (cmd.op)
                    OP_STORE: nbuf_reg <= nbuf_reg + 2'd1;
                    OP_INIT:  seen_reg <= 1'b1;
                    OP_LR2:
                    begin
                        if (cmd.idx == 2'd3)
                            nbuf_reg <= 2'd0;
                    end
                    OP_EMIT:
                    begin
                        full_reg <= 1'b1;
                        nbuf_reg <= 2'd0;
                        len_reg  <= '0;
                        seen_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg <= word_masked;
            cnt_reg  <= cnt_sat;
            last_reg <= in_last;
        end
        if (cmd.apply)
        begin
            case (cmd.op)
                OP_STORE: sbuf_reg[nbuf_reg] <= word_reg;
                OP_INIT:
                begin
                    if (!seen_reg)
                    begin
                        acc_reg[0] <= seed + PRIME1 + PRIME2;
                        acc_reg[1] <= seed + PRIME2;
                        acc_reg[2] <= seed;
                        acc_reg[3] <= seed - PRIME1;
                    end
                end
                OP_LR1:   t_reg <= rotl64(acc_reg[cmd.idx] + prod, 31);
                OP_FA1,
                OP_TW1:   t_reg <= rotl64(prod, 31);
                OP_LR2:
                begin
                    acc_reg[cmd.idx] <= prod;
                    // a last full word that closes a stripe leaves no tail
                    if (cmd.idx == 2'd3 && last_reg)
                        cnt_reg <= '0;
                end
                OP_FOLDSUM:
                    h_reg <= rotl64(acc_reg[0], 1) + rotl64(acc_reg[1], 7) +
                             rotl64(acc_reg[2], 12) + rotl64(acc_reg[3], 18);
                OP_SHORT:  h_reg <= seed + PRIME5;
                OP_ADDLEN: h_reg <= h_reg + len_reg;
                OP_XORT,
                OP_W4A,
                OP_B1:     h_reg <= h_reg ^ prod;
                OP_FA3,
                OP_TW3:    h_reg <= prod + PRIME4;
                OP_W4B:    h_reg <= prod + PRIME3;
                OP_B2,
                OP_AV1,
                OP_AV2:    h_reg <= prod;
                OP_EMIT:   hash_reg <= h_reg ^ (h_reg >> 32);
                default: ;
            endcase
        end
    end

    assign status.last     = last_reg;
    assign status.cnt      = cnt_reg;
    assign status.nbuf     = nbuf_reg;
    assign status.seen     = seen_reg;
    assign status.mul_done = mul_done;
    assign status.out_full = full_reg;

    assign out_valid = full_reg;
    assign out_hash  = hash_reg;

endmodule

/* rtl/xxh_ctrl.sv */
// ----------------------------------------------------------------------------
// xxh_ctrl
// Sequencer: steps the datapath through buffering, stripe rounds, fold,
// tail and avalanche.
// ----------------------------------------------------------------------------
module xxh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  xxh_pkg::xxh_status_t   status,
    output xxh_pkg::xxh_cmd_t      cmd
);
    import xxh_pkg::*;

    xxh_state_t state_reg;
    xxh_state_t state_next;
    logic       busy_reg;
    logic       busy_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       is_mul;
    logic       mul_fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
            pos_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_LR1, ST_LR2, ST_FA1, ST_FA2, ST_FA3, ST_TW1, ST_TW2, ST_TW3,
            ST_W4A, ST_W4B, ST_B1, ST_B2, ST_AV1, ST_AV2: is_mul = 1'b1;
            default:                                     is_mul = 1'b0;
        endcase
    end

    assign mul_fin = is_mul && busy_reg && status.mul_done;

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (status.last)
                begin
                    if (status.cnt == CNT_FULL && status.nbuf == 2'd3)
                        state_next = ST_ABS_INIT;
                    else
                        state_next = ST_FOLD_START;
                end
                else if (status.nbuf == 2'd3)
                    state_next = ST_ABS_INIT;
                else
                    state_next = ST_IDLE;
            end
            ST_ABS_INIT:
            begin
                idx_next   = 2'd0;
                state_next = ST_LR1;
            end
            ST_LR1:
            begin
                if (mul_fin)
                    state_next = ST_LR2;
            end
            ST_LR2:
            begin
                if (mul_fin)
                begin
                    if (idx_reg == 2'd3)
                        state_next = status.last ? ST_FOLD_START : ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_LR1;
                    end
                end
            end
            ST_FOLD_START:
            begin
                idx_next   = 2'd0;
                state_next = status.seen ? ST_FA1 : ST_ADDLEN;
            end
            ST_FA1:
            begin
                if (mul_fin)
                    state_next = ST_FA2;
            end
            ST_FA2:
            begin
                if (mul_fin)
                    state_next = ST_FA3;
            end
            ST_FA3:
            begin
                if (mul_fin)
                begin
                    if (idx_reg == 2'd3)
                        state_next = ST_ADDLEN;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_FA1;
                    end
                end
            end
            ST_ADDLEN:
            begin
                idx_next   = 2'd0;
                state_next = ST_TAIL_CHK;
            end
            ST_TAIL_CHK:
            begin
                if (idx_reg < status.nbuf)
                    state_next = ST_TW1;
                else if (status.cnt == CNT_FULL)
                begin
                    // slot three selects the final word itself
                    idx_next   = 2'd3;
                    state_next = ST_TW1;
                end
                else if (status.cnt >= CNT_HALF)
                    state_next = ST_W4A;
                else
                begin
                    pos_next   = 3'd0;
                    state_next = ST_BYTE_CHK;
                end
            end
            ST_TW1:
            begin
                if (mul_fin)
                    state_next = ST_TW2;
            end
            ST_TW2:
            begin
                if (mul_fin)
                    state_next = ST_TW3;
            end
            ST_TW3:
            begin
                if (mul_fin)
                begin
                    if (idx_reg == 2'd3)
                        state_next = ST_AV1;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_TAIL_CHK;
                    end
                end
            end
            ST_W4A:
            begin
                if (mul_fin)
                    state_next = ST_W4B;
            end
            ST_W4B:
            begin
                if (mul_fin)
                begin
                    pos_next   = 3'd4;
                    state_next = ST_BYTE_CHK;
                end
            end
            ST_BYTE_CHK:
            begin
                if ({1'b0, pos_reg} < status.cnt)
                    state_next = ST_B1;
                else
                    state_next = ST_AV1;
            end
            ST_B1:
            begin
                if (mul_fin)
                    state_next = ST_B2;
            end
            ST_B2:
            begin
                if (mul_fin)
                begin
                    pos_next   = pos_reg + 3'd1;
                    state_next = ST_BYTE_CHK;
                end
            end
            ST_AV1:
            begin
                if (mul_fin)
                    state_next = ST_AV2;
            end
            ST_AV2:
            begin
                if (mul_fin)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.apply     = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.accept    = 1'b0;
        cmd.idx       = idx_reg;
        cmd.pos       = pos_reg;
        in_ready      = 1'b0;
        busy_next     = busy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DISPATCH:
            begin
                cmd.op    = OP_STORE;
                cmd.apply = !status.last && (status.nbuf != 2'd3);
            end
            ST_ABS_INIT:
            begin
                cmd.op    = OP_INIT;
                cmd.apply = 1'b1;
            end
            ST_LR1: cmd.op = OP_LR1;
            ST_LR2: cmd.op = OP_LR2;
            ST_FOLD_START:
            begin
                cmd.op    = status.seen ? OP_FOLDSUM : OP_SHORT;
                cmd.apply = 1'b1;
            end
            ST_FA1: cmd.op = OP_FA1;
            ST_FA2: cmd.op = OP_XORT;
            ST_FA3: cmd.op = OP_FA3;
            ST_ADDLEN:
            begin
                cmd.op    = OP_ADDLEN;
                cmd.apply = 1'b1;
            end
            ST_TW1: cmd.op = OP_TW1;
            ST_TW2: cmd.op = OP_XORT;
            ST_TW3: cmd.op = OP_TW3;
            ST_W4A: cmd.op = OP_W4A;
            ST_W4B: cmd.op = OP_W4B;
            ST_B1:  cmd.op = OP_B1;
            ST_B2:  cmd.op = OP_B2;
            ST_AV1: cmd.op = OP_AV1;
            ST_AV2: cmd.op = OP_AV2;
            ST_EMIT:
            begin
                cmd.op    = OP_EMIT;
                cmd.apply = !status.out_full;
            end
            default: ;
        endcase
        if (is_mul)
        begin
            if (!busy_reg)
            begin
                cmd.mul_start = 1'b1;
                busy_next     = 1'b1;
            end
            else if (status.mul_done)
            begin
                cmd.apply = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

endmodule

/* rtl/xxh64_stream_hash_top.sv */
// ----------------------------------------------------------------------------
// xxh64_stream_hash_top
// XXH64 digest of a stream of little-endian 8-byte message words.
// ----------------------------------------------------------------------------
// Every 64-bit multiply runs on one shared 32x32 multiplier: operand load,
// three partial products, write back; that unit sets the throughput. A word
// that does not close a stripe is only stored in the stripe buffer. A word
// that closes a 32-byte stripe runs eight multiplies. The last word is
// accepted, the fold is set up and the length is added; then come three
// multiplies per folded lane when a stripe was seen, three multiplies and a
// check per buffered or final full word, two multiplies for a 4-byte step,
// two multiplies and a check per trailing byte and two for the avalanche.
// When no full final word remains, a last tail check and a last byte check
// are added. The result register is then loaded once the previous digest
// is taken. A last word that closes a stripe first runs the stripe rounds.
// The digest waits in that register while the next message is accepted.
// The seed is taken when the first stripe of a message completes, or at the
// last word of a short message.
// ----------------------------------------------------------------------------
module xxh64_stream_hash_top (
    input  logic                       clk,
    input  logic                       rst_n,
    xxh_in_if.sink                     in_ch,
    xxh_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xxh_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    import xxh_pkg::*;

    logic [63:0] seed_reg;
    xxh_cmd_t    cmd;
    xxh_status_t status;
    logic        in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (psel && penable && pwrite && paddr == REG_SEED)
            seed_reg <= pwdata;
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SEED) ? seed_reg : '0;

    assign in_ch.ready = in_ready;

    xxh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    xxh_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .seed      (seed_reg),
        .in_word   (in_ch.data_word),
        .in_count  (in_ch.byte_count),
        .in_last   (in_ch.last),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_hash  (out_ch.hash)
    );

endmodule

/* rtl/xxh_checker.sv */
// ----------------------------------------------------------------------------
// xxh_checker
// Port-level checks on the XXH64 block, bound to the top level.
// ----------------------------------------------------------------------------
module xxh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_hash,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hash))
        else $error("digest dropped or changed while stalled");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input taken right after a last word");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("digest appeared while input side was idle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind xxh64_stream_hash_top xxh_checker u_xxh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_hash  (out_ch.hash),
    .pready    (pready)
);
